// ===== rtl/rdsm_pkg.sv =====
// Shared types and constants for the regex dot-star matcher.
// Holds the request codes, the token kinds and the bus passed from cell to cell.
// No dependencies.
package rdsm_pkg;

  // Default number of pattern cells
  localparam int DEF_PATTERN_LEN = 32;

  // Field widths fixed by the interface
  localparam int REQ_W  = 2;
  localparam int POS_W  = 5;
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 6;

  // Request codes on in_req_type
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TEXT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  // Special pattern bytes
  localparam logic [BYTE_W-1:0] CH_STAR = 8'd42;
  localparam logic [BYTE_W-1:0] CH_DOT  = 8'd46;

  // Configuration register index (byte address bit 2)
  localparam logic CFG_PATTERN_LENGTH = 1'b0;

  // Kind of token traveling down the chain
  typedef enum logic [1:0] {
    TOK_IDLE,
    TOK_WRITE,
    TOK_TEXT,
    TOK_FINISH
  } tok_kind_t;

  // Token plus the column bits each cell hands to its right neighbor
  typedef struct packed {
    tok_kind_t         kind;
    logic              fresh;   // first text byte, or finish with no text
    logic              lead;    // set only by the head: next cell is position 0
    logic [BYTE_W-1:0] data;    // text byte or pattern byte to write
    logic [POS_W-1:0]  pos;     // pattern position to write
    logic [BYTE_W-1:0] pat;     // pattern byte of the sending cell
    logic              nb;      // new column bit of the sending cell
    logic              nb_up;   // new column bit one cell further left
    logic              ob;      // old column bit of the sending cell
    logic              ib;      // empty-text column bit of the sending cell
    logic              ib_up;   // empty-text column bit one cell further left
    logic              res;     // match result collected so far
  } cell_bus_t;

endpackage

// ===== rtl/rdsm_head.sv =====
// Ingress stage of the regex dot-star matcher: turns a request into a chain token.
// Tracks the start-of-text flag and seeds column bit zero.
// Depends on rdsm_pkg.
module rdsm_head #(
  parameter int LEN_W = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      take,
  input  logic [rdsm_pkg::REQ_W-1:0]  req_type,
  input  logic [rdsm_pkg::POS_W-1:0]  position,
  input  logic [rdsm_pkg::BYTE_W-1:0] value,
  input  logic [LEN_W-1:0]          len_eff,
  output rdsm_pkg::cell_bus_t       bus_out
);
  import rdsm_pkg::*;

  cell_bus_t bus_r, bus_nxt;
  logic      at_start_r, at_start_nxt;
  tok_kind_t kind;

  // Decode the request
  always_comb begin
    unique case (req_type)
      REQ_WRITE:  kind = TOK_WRITE;
      REQ_TEXT:   kind = TOK_TEXT;
      REQ_FINISH: kind = TOK_FINISH;
      default:    kind = TOK_IDLE;
    endcase
  end

  // Build the token; column bit zero is zero after any text byte
  always_comb begin
    bus_nxt       = '0;
    bus_nxt.kind  = take ? kind : TOK_IDLE;
    bus_nxt.fresh = at_start_r;
    bus_nxt.lead  = 1'b1;
    bus_nxt.data  = value;
    bus_nxt.pos   = position;
    bus_nxt.ib    = 1'b1;
    bus_nxt.ib_up = 1'b1;
    bus_nxt.res   = (len_eff == '0) ? at_start_r : 1'b0;

    // Rearm on finish, drop the flag on the first text byte
    at_start_nxt = at_start_r;
    if (take && kind == TOK_TEXT) begin
      at_start_nxt = 1'b0;
    end else if (take && kind == TOK_FINISH) begin
      at_start_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r   <= 1'b1;
      bus_r.kind   <= TOK_IDLE;
    end else if (adv) begin
      at_start_r   <= at_start_nxt;
      bus_r        <= bus_nxt;
    end
  end

  assign bus_out = bus_r;

endmodule

// ===== rtl/rdsm_cell.sv =====
// One pattern position of the regex dot-star matcher chain.
// Holds its pattern byte and its column bit, updates them as tokens pass.
// Depends on rdsm_pkg.
module rdsm_cell #(
  parameter int PATTERN_LEN = rdsm_pkg::DEF_PATTERN_LEN,
  parameter int IDX         = 0,
  parameter int LEN_W       = $clog2(PATTERN_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [LEN_W-1:0]    len_eff,
  input  rdsm_pkg::cell_bus_t bus_in,
  output rdsm_pkg::cell_bus_t bus_out
);
  import rdsm_pkg::*;

  logic [BYTE_W-1:0] pat_r, pat_nxt;
  logic              col_r, col_nxt;
  cell_bus_t         bus_r, bus_nxt;

  logic m_own, m_up, is_star;
  logic ib_n, old_mine, old_up, n_text, v_fin;

  // Column update for this position
  always_comb begin
    m_own    = (pat_r == CH_DOT) || (pat_r == bus_in.data);
    m_up     = (bus_in.pat == CH_DOT) || (bus_in.pat == bus_in.data);
    is_star  = (pat_r == CH_STAR);

    // Empty-text column: a star copies the bit two positions back
    ib_n     = is_star ? (bus_in.lead ? bus_in.ib : bus_in.ib_up) : 1'b0;

    // On the first text byte the old column is the empty-text column
    old_mine = bus_in.fresh ? ib_n : col_r;
    old_up   = bus_in.fresh ? bus_in.ib : bus_in.ob;

    if (is_star) begin
      n_text = bus_in.lead ? bus_in.nb : (bus_in.nb_up | (m_up & old_mine));
    end else begin
      n_text = m_own & old_up;
    end

    v_fin = bus_in.fresh ? ib_n : col_r;
  end

  // Apply the token and forward it
  always_comb begin
    col_nxt = col_r;
    pat_nxt = pat_r;

    bus_nxt       = bus_in;
    bus_nxt.lead  = 1'b0;
    bus_nxt.pat   = pat_r;
    bus_nxt.nb    = col_r;
    bus_nxt.nb_up = bus_in.nb;
    bus_nxt.ob    = col_r;
    bus_nxt.ib    = ib_n;
    bus_nxt.ib_up = bus_in.ib;

    case (bus_in.kind)
      TOK_TEXT: begin
        col_nxt    = n_text;
        bus_nxt.nb = n_text;
      end
      TOK_WRITE: begin
        if (int'(bus_in.pos) == IDX) begin
          pat_nxt = bus_in.data;
        end
      end
      TOK_FINISH: begin
        if (len_eff == LEN_W'(IDX + 1)) begin
          bus_nxt.res = v_fin;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= 1'b0;
      bus_r.kind <= TOK_IDLE;
    end else if (adv) begin
      col_r      <= col_nxt;
      bus_r      <= bus_nxt;
    end
  end

  // Pattern byte carries no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      pat_r <= pat_nxt;
    end
  end

  assign bus_out = bus_r;

endmodule

// ===== rtl/regex_dot_star_matcher_core.sv =====
// Regex dot-star matcher: whole-text match of streamed bytes against a pattern.
// Takes one transaction per cycle unless the chain is stalled; a finish result passes
// through the head register, the register of each pattern cell in turn, then the output register.
// A result waiting at the output stalls the whole cell chain and the input once
// the next finish reaches the tail.
// Synchronous active-low reset clears pattern_length, the column and the text flag;
// pattern bytes stay undefined until written.
// Depends on rdsm_pkg, rdsm_head, rdsm_cell.
module regex_dot_star_matcher_core #(
  parameter int PATTERN_LEN = rdsm_pkg::DEF_PATTERN_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rdsm_pkg::REQ_W-1:0]  in_req_type,
  input  logic [rdsm_pkg::POS_W-1:0]  in_position,
  input  logic [rdsm_pkg::BYTE_W-1:0] in_value,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_matched,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rdsm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_LEN + 1);

  logic [PLEN_W-1:0] plen_r;
  logic [LEN_W-1:0]  len_eff;
  logic              adv, take;
  cell_bus_t         chain_bus [PATTERN_LEN+1];
  cell_bus_t         tail;
  logic              out_valid_r, out_matched_r;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == CFG_PATTERN_LENGTH) begin
      plen_r <= pwdata[PLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_PATTERN_LENGTH) ? {{(32-PLEN_W){1'b0}}, plen_r} : '0;

  // Clamp the length to the number of cells
  always_comb begin
    if (int'(plen_r) > PATTERN_LEN) begin
      len_eff = LEN_W'(PATTERN_LEN);
    end else begin
      len_eff = LEN_W'(plen_r);
    end
  end

  // Advance the chain unless a result is waiting at the tail with nowhere to go
  assign tail     = chain_bus[PATTERN_LEN];
  assign adv      = !(tail.kind == TOK_FINISH && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign take     = in_valid && adv;

  rdsm_head #(
    .LEN_W(LEN_W)
  ) u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .take    (take),
    .req_type(in_req_type),
    .position(in_position),
    .value   (in_value),
    .len_eff (len_eff),
    .bus_out (chain_bus[0])
  );

  // One cell per pattern position
  for (genvar g = 0; g < PATTERN_LEN; g++) begin : g_cell
    rdsm_cell #(
      .PATTERN_LEN(PATTERN_LEN),
      .IDX        (g),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .len_eff(len_eff),
      .bus_in (chain_bus[g]),
      .bus_out(chain_bus[g+1])
    );
  end

  // Output register: load a finish result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && tail.kind == TOK_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.kind == TOK_FINISH) begin
      out_matched_r <= tail.res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule
